// ===== hw/rtl/lbp_pkg.sv =====
// ============================================================================
// lbp_pkg: shared types and constants of the LED breathing PWM controller
// Transfer payloads, register indexes, mode codes and the handshake structs
// of the serial divide and multiply units.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lbp_pkg;

   // channel count and field widths
   localparam int CHANNELS   = 3;
   localparam int PWM_W      = 17;
   localparam int BREATH_W   = 16;
   localparam int DUTY_W     = 7;
   localparam int MODE_W     = 3;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // serial divider: 32-bit dividend, 16-bit divisor
   localparam int DIV_N_W = 32;
   localparam int DIV_D_W = 16;

   // serial multiplier: 17-bit multiplicand, 33-bit multiplier
   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 33;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_PERIOD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BREATH_PERIOD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_CH0    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_CH1    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_CH2    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_MASK   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL      = 3'd6;

   // register reset values
   localparam logic [PWM_W-1:0]      RST_PWM_PERIOD    = 17'd1000;
   localparam logic [BREATH_W-1:0]   RST_BREATH_PERIOD = 16'd3000;
   localparam logic [BREATH_W-1:0]   RST_OFFSET_CH0    = 16'd0;
   localparam logic [BREATH_W-1:0]   RST_OFFSET_CH1    = 16'd1000;
   localparam logic [BREATH_W-1:0]   RST_OFFSET_CH2    = 16'd2000;
   localparam logic [CHANNELS-1:0]   RST_INVERT_MASK   = 3'd0;
   localparam logic [INTERVAL_W-1:0] RST_INTERVAL      = 8'd10;

   // operations
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_MODE = 1'b1;

   // breathing modes
   localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BLUE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_GREEN = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RED   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FULL  = 3'd4;

   // scale factor for duty percent
   localparam logic [MUL_A_W-1:0] PCT_SCALE = 17'd100;
   // progress full scale, 1.0 in Q1.16
   localparam logic [MUL_A_W-1:0] PROG_ONE  = 17'h10000;

   typedef struct packed {
      logic              operation;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [PWM_W-1:0]  compare_ch0;
      logic [PWM_W-1:0]  compare_ch1;
      logic [PWM_W-1:0]  compare_ch2;
      logic [DUTY_W-1:0] duty_pct_ch0;
      logic [DUTY_W-1:0] duty_pct_ch1;
      logic [DUTY_W-1:0] duty_pct_ch2;
      logic [MODE_W-1:0] mode;
      logic              updated;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
      logic [DIV_D_W-1:0] remainder;
   } div_res_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] multiplicand;
      logic [MUL_B_W-1:0] multiplier;
   } mul_cmd_type;

   typedef struct packed {
      logic               done;
      logic [MUL_P_W-1:0] product;
   } mul_res_type;

   // mode sequence off, blue, green, red, full, off
   function automatic logic [MODE_W-1:0] mode_next(input logic [MODE_W-1:0] m);
      logic [MODE_W-1:0] n;
      unique case (m)
         MODE_OFF:   n = MODE_BLUE;
         MODE_BLUE:  n = MODE_GREEN;
         MODE_GREEN: n = MODE_RED;
         MODE_RED:   n = MODE_FULL;
         MODE_FULL:  n = MODE_OFF;
         default:    n = MODE_BLUE;
      endcase
      return n;
   endfunction

   // channels lit in each mode
   function automatic logic [CHANNELS-1:0] mode_enables(input logic [MODE_W-1:0] m);
      logic [CHANNELS-1:0] e;
      unique case (m)
         MODE_BLUE:  e = 3'b001;
         MODE_GREEN: e = 3'b010;
         MODE_RED:   e = 3'b100;
         MODE_FULL:  e = 3'b111;
         default:    e = 3'b000;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lbp_div.sv =====
// ============================================================================
// lbp_div: bit-serial restoring divider
// One quotient bit per cycle, 32 steps; quotient and remainder stay in their
// registers after the one-cycle done pulse.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lbp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lbp_pkg::div_cmd_type cmd,
   output lbp_pkg::div_res_type res
);
   import lbp_pkg::*;

   localparam int CNT_W = $clog2(DIV_N_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_N_W - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_N_W-1:0] dvd_ff, dvd_in;
   logic [DIV_D_W-1:0] dsr_ff, dsr_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W:0]   cand;
   logic [DIV_D_W:0]   diff;
   logic               fits;

   // one restoring step: shift in next dividend bit, subtract when it fits
   always_comb begin
      cand    = {rem_ff, dvd_ff[DIV_N_W-1]};
      diff    = cand - {1'b0, dsr_ff};
      fits    = cand >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_D_W-1:0] : cand[DIV_D_W-1:0];
         dvd_in = {dvd_ff[DIV_N_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign res.done      = done_ff;
   assign res.quotient  = dvd_ff;
   assign res.remainder = rem_ff;

`ifndef SYNTHESIS
   // done is a single-cycle pulse
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");

   // remainder below the divisor when the result is offered
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (done_ff && dsr_ff != '0) |-> (rem_ff < dsr_ff))
      else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_mul.sv =====
// ============================================================================
// lbp_mul: bit-serial shift-add multiplier
// Takes one multiplier bit per cycle, 33 steps, with a 17-bit adder; the full
// 50-bit product stays in its registers after the one-cycle done pulse.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lbp_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  lbp_pkg::mul_cmd_type cmd,
   output lbp_pkg::mul_res_type res
);
   import lbp_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_B_W - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MUL_A_W-1:0] mcand_ff, mcand_in;
   logic [MUL_B_W-1:0] mplier_ff, mplier_in;
   logic [MUL_A_W-1:0] hi_ff, hi_in;
   logic [MUL_B_W-1:0] lo_ff, lo_in;
   logic [MUL_A_W:0]   sum;

   // one step: add multiplicand on a set bit, shift the partial product right
   always_comb begin
      sum       = {1'b0, hi_ff} + (mplier_ff[0] ? {1'b0, mcand_ff} : '0);
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      if (cmd.start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mcand_in  = cmd.multiplicand;
         mplier_in = cmd.multiplier;
         hi_in     = '0;
         lo_in     = '0;
      end else if (busy_ff) begin
         hi_in     = sum[MUL_A_W:1];
         lo_in     = {sum[0], lo_ff[MUL_B_W-1:1]};
         mplier_in = {1'b0, mplier_ff[MUL_B_W-1:1]};
         cnt_in    = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
   end

   assign res.done    = done_ff;
   assign res.product = {hi_ff, lo_ff};

endmodule

`default_nettype wire

// ===== hw/rtl/led_breathing_pwm_controller.sv =====
// ============================================================================
// led_breathing_pwm_controller: three-channel LED breathing controller
// Turns millisecond ticks and mode presses into PWM compare values and duty
// percentages for blue, green and red channels.
// ============================================================================
// Usage:
//  - req channel (valid/ready) carries one item: a tick with now_ms, or a
//    mode press. rsp channel returns exactly one result per item, holding
//    the three compare values, duty percents, current mode and an updated flag.
//  - csr port writes one register per cycle with csr_wr_en; write only while
//    the block is idle. There is no read-back.
//  - One item at a time. A mode press passes the mode step and a tick the
//    interval check before the hand-off; a tick that updates first runs each
//    lit channel through two 32-step passes of the bit-serial divider (phase
//    modulo, progress; the progress pass is skipped for a breathing period of
//    one) and three 33-step passes of the bit-serial multiplier (square,
//    pulse, percent). A zero breathing period leaves every channel as it is.
//  - The result sits in an output register; a new item is taken while it
//    waits, and only the hand-off of the next result stalls on rsp_ready.
//  - Synchronous reset returns registers to defaults, mode to off, all
//    compare and duty values and the time keeping to zero.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module led_breathing_pwm_controller (
   input  logic                                  clock,
   input  logic                                  reset,
   // item channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lbp_pkg::req_type                      req_data,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lbp_pkg::rsp_type                      rsp_data,
   // register write port
   input  logic                                  csr_wr_en,
   input  logic [lbp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import lbp_pkg::*;

   localparam int CH_W = $clog2(CHANNELS);
   localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

   typedef enum logic [9:0] {
      S_IDLE       = 10'b0000000001,
      S_MODE       = 10'b0000000010,
      S_CHECK      = 10'b0000000100,
      S_CH_SEL     = 10'b0000001000,
      S_MOD_WAIT   = 10'b0000010000,
      S_DIV_WAIT   = 10'b0000100000,
      S_SQ_WAIT    = 10'b0001000000,
      S_PULSE_WAIT = 10'b0010000000,
      S_DUTY_WAIT  = 10'b0100000000,
      S_DONE       = 10'b1000000000
   } state_type;

   // registers
   logic [PWM_W-1:0]      pwm_period_ff;
   logic [BREATH_W-1:0]   breath_period_ff;
   logic [BREATH_W-1:0]   offset_ff [CHANNELS];
   logic [CHANNELS-1:0]   invert_ff;
   logic [INTERVAL_W-1:0] interval_ff;

   // control and state
   state_type             state_ff, state_in;
   logic [TIME_W-1:0]     last_update_ff, last_update_in;
   logic [TIME_W-1:0]     elapsed_ff, elapsed_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [PWM_W-1:0]      compare_ff [CHANNELS];
   logic [PWM_W-1:0]      compare_in [CHANNELS];
   logic [DUTY_W-1:0]     duty_ff [CHANNELS];
   logic [DUTY_W-1:0]     duty_in [CHANNELS];
   logic [CH_W-1:0]       ch_ff, ch_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // per-item payload
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [TIME_W-1:0]     dt_ff, dt_in;
   logic [PWM_W-1:0]      before_ff [CHANNELS];
   logic [PWM_W-1:0]      before_in [CHANNELS];
   logic                  rising_ff, rising_in;
   logic [MUL_B_W-1:0]    sq_ff, sq_in;
   logic [PWM_W-1:0]      pulse_ff, pulse_in;
   rsp_type               rsp_ff, rsp_in;

   // serial units
   div_cmd_type           div_cmd;
   div_res_type           div_res;
   mul_cmd_type           mul_cmd;
   mul_res_type           mul_res;

   // combinational helpers
   logic [MODE_W-1:0]     nxt_mode;
   logic [CHANNELS-1:0]   nxt_en;
   logic [CHANNELS-1:0]   cur_en;
   logic [BREATH_W-2:0]   half;
   logic [BREATH_W-1:0]   phase;
   logic                  phase_rising;
   logic [BREATH_W-1:0]   prog_num;
   logic [MUL_A_W-1:0]    prog;
   logic [MUL_A_W-1:0]    level;
   logic [9:0]            pct_rnd;
   logic [PWM_W-1:0]      inv_pulse;
   logic                  changed;

   lbp_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   lbp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .res   (mul_res)
   );

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff    <= RST_PWM_PERIOD;
         breath_period_ff <= RST_BREATH_PERIOD;
         offset_ff[0]     <= RST_OFFSET_CH0;
         offset_ff[1]     <= RST_OFFSET_CH1;
         offset_ff[2]     <= RST_OFFSET_CH2;
         invert_ff        <= RST_INVERT_MASK;
         interval_ff      <= RST_INTERVAL;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PWM_PERIOD:    pwm_period_ff    <= csr_wdata;
            CSR_BREATH_PERIOD: breath_period_ff <= csr_wdata[BREATH_W-1:0];
            CSR_OFFSET_CH0:    offset_ff[0]     <= csr_wdata[BREATH_W-1:0];
            CSR_OFFSET_CH1:    offset_ff[1]     <= csr_wdata[BREATH_W-1:0];
            CSR_OFFSET_CH2:    offset_ff[2]     <= csr_wdata[BREATH_W-1:0];
            CSR_INVERT_MASK:   invert_ff        <= csr_wdata[CHANNELS-1:0];
            CSR_INTERVAL:      interval_ff      <= csr_wdata[INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   // phase, progress and output shaping
   always_comb begin
      nxt_mode     = mode_next(mode_ff);
      nxt_en       = mode_enables(nxt_mode);
      cur_en       = mode_enables(mode_ff);
      half         = breath_period_ff[BREATH_W-1:1];
      phase        = div_res.remainder;
      phase_rising = phase < {1'b0, half};
      prog_num     = phase_rising ? phase : phase - {1'b0, half};
      prog         = div_res.quotient[MUL_A_W-1:0];
      level        = rising_ff ? prog : PROG_ONE - prog;
      // round half up: (s * 100 + 2^31) >> 32
      pct_rnd      = {1'b0, mul_res.product[39:31]} + 10'd1;
      inv_pulse    = (pwm_period_ff > pulse_ff) ? pwm_period_ff - pulse_ff : '0;
      changed      = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (compare_ff[c] != before_ff[c]) begin
            changed = 1'b1;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      last_update_in = last_update_ff;
      elapsed_in     = elapsed_ff;
      mode_in        = mode_ff;
      compare_in     = compare_ff;
      duty_in        = duty_ff;
      ch_in          = ch_ff;
      now_in         = now_ff;
      dt_in          = dt_ff;
      before_in      = before_ff;
      rising_in      = rising_ff;
      sq_in          = sq_ff;
      pulse_in       = pulse_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      div_cmd        = '0;
      mul_cmd        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in    = req_data.now_ms;
               dt_in     = req_data.now_ms - last_update_ff;
               before_in = compare_ff;
               state_in  = (req_data.operation == OP_MODE) ? S_MODE : S_CHECK;
            end
         end

         // step the mode, park channels that the new mode leaves dark
         S_MODE: begin
            mode_in = nxt_mode;
            for (int c = 0; c < CHANNELS; c++) begin
               if (!nxt_en[c]) begin
                  compare_in[c] = invert_ff[c] ? pwm_period_ff : '0;
                  duty_in[c]    = '0;
               end
            end
            state_in = S_DONE;
         end

         // update only once the interval has passed
         S_CHECK: begin
            if (dt_ff >= {{(TIME_W-INTERVAL_W){1'b0}}, interval_ff}) begin
               last_update_in = now_ff;
               elapsed_in     = elapsed_ff + dt_ff;
               ch_in          = '0;
               state_in       = S_CH_SEL;
            end else begin
               state_in = S_DONE;
            end
         end

         // phase = (elapsed + offset) mod breathing period
         S_CH_SEL: begin
            if (cur_en[ch_ff] && breath_period_ff != '0) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = elapsed_ff + {{(TIME_W-BREATH_W){1'b0}}, offset_ff[ch_ff]};
               div_cmd.divisor  = breath_period_ff;
               state_in         = S_MOD_WAIT;
            end else if (ch_ff == CH_LAST) begin
               state_in = S_DONE;
            end else begin
               ch_in = ch_ff + CH_W'(1);
            end
         end

         // progress = (x << 16) / half; a period of one gives level zero
         S_MOD_WAIT: begin
            if (div_res.done) begin
               rising_in = phase_rising;
               if (half == '0) begin
                  mul_cmd.start = 1'b1;
                  state_in      = S_SQ_WAIT;
               end else begin
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = {prog_num, {(DIV_N_W-BREATH_W){1'b0}}};
                  div_cmd.divisor  = {1'b0, half};
                  state_in         = S_DIV_WAIT;
               end
            end
         end

         // square the triangle level
         S_DIV_WAIT: begin
            if (div_res.done) begin
               mul_cmd.start        = 1'b1;
               mul_cmd.multiplicand = level;
               mul_cmd.multiplier   = {{(MUL_B_W-MUL_A_W){1'b0}}, level};
               state_in             = S_SQ_WAIT;
            end
         end

         // pulse = period * s >> 32
         S_SQ_WAIT: begin
            if (mul_res.done) begin
               sq_in                = mul_res.product[MUL_B_W-1:0];
               mul_cmd.start        = 1'b1;
               mul_cmd.multiplicand = pwm_period_ff;
               mul_cmd.multiplier   = mul_res.product[MUL_B_W-1:0];
               state_in             = S_PULSE_WAIT;
            end
         end

         // duty percent from s * 100
         S_PULSE_WAIT: begin
            if (mul_res.done) begin
               pulse_in             = mul_res.product[48:32];
               mul_cmd.start        = 1'b1;
               mul_cmd.multiplicand = PCT_SCALE;
               mul_cmd.multiplier   = sq_ff;
               state_in             = S_DUTY_WAIT;
            end
         end

         // store channel results, move on
         S_DUTY_WAIT: begin
            if (mul_res.done) begin
               duty_in[ch_ff]    = pct_rnd[DUTY_W:1];
               compare_in[ch_ff] = invert_ff[ch_ff] ? inv_pulse : pulse_ff;
               if (ch_ff == CH_LAST) begin
                  state_in = S_DONE;
               end else begin
                  ch_in    = ch_ff + CH_W'(1);
                  state_in = S_CH_SEL;
               end
            end
         end

         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.compare_ch0  = compare_ff[0];
               rsp_in.compare_ch1  = compare_ff[1];
               rsp_in.compare_ch2  = compare_ff[2];
               rsp_in.duty_pct_ch0 = duty_ff[0];
               rsp_in.duty_pct_ch1 = duty_ff[1];
               rsp_in.duty_pct_ch2 = duty_ff[2];
               rsp_in.mode         = mode_ff;
               rsp_in.updated      = changed;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         last_update_ff <= '0;
         elapsed_ff     <= '0;
         mode_ff        <= MODE_OFF;
         ch_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            compare_ff[c] <= '0;
            duty_ff[c]    <= '0;
         end
      end else begin
         state_ff       <= state_in;
         last_update_ff <= last_update_in;
         elapsed_ff     <= elapsed_in;
         mode_ff        <= mode_in;
         ch_ff          <= ch_in;
         rsp_valid_ff   <= rsp_valid_in;
         compare_ff     <= compare_in;
         duty_ff        <= duty_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      now_ff    <= now_in;
      dt_ff     <= dt_in;
      before_ff <= before_in;
      rising_ff <= rising_in;
      sq_ff     <= sq_in;
      pulse_ff  <= pulse_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a tick transfer goes to the interval check
   a_tick_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.operation == OP_TICK) |=> (state_ff == S_CHECK))
      else $error("tick transfer did not reach interval check");

   // a press transfer goes to the mode step
   a_press_mode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.operation == OP_MODE) |=> (state_ff == S_MODE))
      else $error("press transfer did not reach mode step");

   // duty percentages never exceed 100
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      (duty_ff[0] <= 7'd100) && (duty_ff[1] <= 7'd100) && (duty_ff[2] <= 7'd100))
      else $error("duty percent out of range");

   // a finished item lands in the output register and the block goes idle
   a_done_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) |=>
      (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result hand-off failed");
`endif

endmodule

`default_nettype wire

// ===== dv/led_breathing_pwm_checker.sv =====
// ============================================================================
// led_breathing_pwm_checker: result predictor and scoreboard
// Watches the item, result and register ports of the breathing controller.
// It keeps its own copy of the registers and the timing, mode and channel
// state, works out the result of each item at its transfer, and compares
// every result transfer field by field with the oldest one still owed.
// ============================================================================
`timescale 1ns / 1ps

module led_breathing_pwm_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  lbp_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  lbp_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [lbp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lbp_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             error_count,
   output int                             results_owed
);
   import lbp_pkg::*;

   // only the first mismatches are printed, all are counted
   localparam int PRINT_CAP = 40;

   // register copies
   logic [PWM_W-1:0]      pwm_period;
   logic [BREATH_W-1:0]   breath_period;
   logic [BREATH_W-1:0]   phase_offset [CHANNELS];
   logic [CHANNELS-1:0]   invert_mask;
   logic [INTERVAL_W-1:0] update_interval;

   // timing, mode and channel state
   logic [TIME_W-1:0]     last_update;
   logic [TIME_W-1:0]     elapsed;
   logic [MODE_W-1:0]     breath_mode;
   logic [PWM_W-1:0]      compare_val [CHANNELS];
   logic [DUTY_W-1:0]     duty_val [CHANNELS];

   // results owed by the block, oldest first
   rsp_type owed_frames [$];

   // channels lit in a mode
   function automatic logic [CHANNELS-1:0] lit_channels(input logic [MODE_W-1:0] m);
      logic [CHANNELS-1:0] lit;
      case (m)
         MODE_BLUE:  lit = 3'b001;
         MODE_GREEN: lit = 3'b010;
         MODE_RED:   lit = 3'b100;
         MODE_FULL:  lit = 3'b111;
         default:    lit = 3'b000;
      endcase
      return lit;
   endfunction

   // squared triangle progress, q1.32
   function automatic logic [63:0] level_squared(input logic [TIME_W-1:0] t,
                                                 input logic [BREATH_W-1:0] period);
      logic [63:0] half;
      logic [63:0] prog;
      half = {48'd0, period} >> 1;
      // period of one has no halves, progress stays at zero
      if (half == 64'd0)
         return 64'd0;
      if ({32'd0, t} < half)
         prog = ({32'd0, t} << 16) / half;
      else
         prog = 64'd65536 - ((({32'd0, t}) - half) << 16) / half;
      return prog * prog;
   endfunction

   // scale pulse and duty percent from a squared level, then invert
   function automatic void set_level(input int ch, input logic [63:0] sq);
      logic [63:0] per;
      logic [63:0] prod;
      logic [63:0] pulse;
      logic [63:0] scaled;
      per    = {47'd0, pwm_period};
      prod   = per * sq;
      pulse  = prod >> 32;
      scaled = sq * 64'd100 + 64'h8000_0000;
      duty_val[ch] = scaled[32 +: DUTY_W];
      if (invert_mask[ch])
         pulse = (per > pulse) ? per - pulse : 64'd0;
      compare_val[ch] = pulse[PWM_W-1:0];
   endfunction

   // advance the state by one item and return its result
   function automatic rsp_type predict_frame(input req_type item);
      logic [PWM_W-1:0]    prior [CHANNELS];
      logic [CHANNELS-1:0] lit;
      logic [TIME_W-1:0]   delta;
      logic [TIME_W-1:0]   t;
      rsp_type             frame;
      int                  c;
      for (c = 0; c < CHANNELS; c++)
         prior[c] = compare_val[c];
      if (item.operation == OP_MODE) begin
         // press: step the mode and blank the channels it leaves dark
         case (breath_mode)
            MODE_OFF:   breath_mode = MODE_BLUE;
            MODE_BLUE:  breath_mode = MODE_GREEN;
            MODE_GREEN: breath_mode = MODE_RED;
            MODE_RED:   breath_mode = MODE_FULL;
            MODE_FULL:  breath_mode = MODE_OFF;
            default:    breath_mode = MODE_BLUE;
         endcase
         lit = lit_channels(breath_mode);
         for (c = 0; c < CHANNELS; c++)
            if (!lit[c])
               set_level(c, 64'd0);
      end else begin
         // tick: update once the wrapped gap reaches the interval
         delta = item.now_ms - last_update;
         if (delta >= {24'd0, update_interval}) begin
            lit = lit_channels(breath_mode);
            last_update = item.now_ms;
            elapsed = elapsed + delta;
            // zero breathing period leaves lit channels as they are
            for (c = 0; c < CHANNELS; c++)
               if (lit[c] && breath_period != '0) begin
                  t = (elapsed + {16'd0, phase_offset[c]}) % {16'd0, breath_period};
                  set_level(c, level_squared(t, breath_period));
               end
         end
      end
      frame.compare_ch0  = compare_val[0];
      frame.compare_ch1  = compare_val[1];
      frame.compare_ch2  = compare_val[2];
      frame.duty_pct_ch0 = duty_val[0];
      frame.duty_pct_ch1 = duty_val[1];
      frame.duty_pct_ch2 = duty_val[2];
      frame.mode         = breath_mode;
      frame.updated      = (prior[0] != compare_val[0]) || (prior[1] != compare_val[1]) ||
                           (prior[2] != compare_val[2]);
      return frame;
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_CAP)
         $display("%0t ns: mismatch: %s", $time, what);
      error_count = error_count + 1;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, predicted %0h", name, got, want));
   endtask

   // monitor: register writes, result transfers, item transfers
   always @(posedge clock) begin : monitor
      rsp_type want;
      int c;
      if (reset) begin
         pwm_period      = RST_PWM_PERIOD;
         breath_period   = RST_BREATH_PERIOD;
         phase_offset[0] = RST_OFFSET_CH0;
         phase_offset[1] = RST_OFFSET_CH1;
         phase_offset[2] = RST_OFFSET_CH2;
         invert_mask     = RST_INVERT_MASK;
         update_interval = RST_INTERVAL;
         last_update     = '0;
         elapsed         = '0;
         breath_mode     = MODE_OFF;
         for (c = 0; c < CHANNELS; c++) begin
            compare_val[c] = '0;
            duty_val[c]    = '0;
         end
         owed_frames.delete();
         error_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PWM_PERIOD:    pwm_period      = csr_wdata[PWM_W-1:0];
               CSR_BREATH_PERIOD: breath_period   = csr_wdata[BREATH_W-1:0];
               CSR_OFFSET_CH0:    phase_offset[0] = csr_wdata[BREATH_W-1:0];
               CSR_OFFSET_CH1:    phase_offset[1] = csr_wdata[BREATH_W-1:0];
               CSR_OFFSET_CH2:    phase_offset[2] = csr_wdata[BREATH_W-1:0];
               CSR_INVERT_MASK:   invert_mask     = csr_wdata[CHANNELS-1:0];
               CSR_INTERVAL:      update_interval = csr_wdata[INTERVAL_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_frames.size() == 0) begin
               report_mismatch("result transfer with no result owed");
            end else begin
               want = owed_frames.pop_front();
               check_field("compare_ch0", rsp_data.compare_ch0, want.compare_ch0);
               check_field("compare_ch1", rsp_data.compare_ch1, want.compare_ch1);
               check_field("compare_ch2", rsp_data.compare_ch2, want.compare_ch2);
               check_field("duty_pct_ch0", rsp_data.duty_pct_ch0, want.duty_pct_ch0);
               check_field("duty_pct_ch1", rsp_data.duty_pct_ch1, want.duty_pct_ch1);
               check_field("duty_pct_ch2", rsp_data.duty_pct_ch2, want.duty_pct_ch2);
               check_field("mode", rsp_data.mode, want.mode);
               check_field("updated", rsp_data.updated, want.updated);
            end
         end
         if (req_valid && req_ready)
            owed_frames.push_back(predict_frame(req_data));
      end
      results_owed <= owed_frames.size();
   end

endmodule

// ===== dv/led_breathing_pwm_controller_tb.sv =====
// ============================================================================
// led_breathing_pwm_controller_tb: testbench top of the breathing controller
// Drives ticks and mode presses through a directed part and random phases
// under several register settings and idling patterns, with one long result
// hold-off; the checker beside the block predicts and compares every result.
// ============================================================================
`timescale 1ns / 1ps

module led_breathing_pwm_controller_tb;
   import lbp_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int SETTLE_TIME  = 600;
   localparam int GAP_CAP      = 60;
   localparam int HOLD_CYCLES  = 300;
   // index past the last register, writes to it must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count;
   int results_owed;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_request       = 0;
   int quiet_cycles       = 0;

   // stimulus-side view of time, mode and timing registers
   logic [TIME_W-1:0]     clock_ms    = '0;
   logic [MODE_W-1:0]     tb_mode     = MODE_OFF;
   logic [INTERVAL_W-1:0] tb_interval = RST_INTERVAL;
   logic [BREATH_W-1:0]   tb_breath   = RST_BREATH_PERIOD;

   led_breathing_pwm_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   led_breathing_pwm_checker scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .results_owed (results_owed)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("led_breathing_pwm_controller_tb: done, errors");
         $finish;
      end
   end

   // result receiver: random stalls, or a long hold-off on request
   initial begin : receiver
      int hold_len;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_len = hold_request;
            hold_request = 0;
            rsp_ready <= 1'b0;
            repeat (hold_len) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   // offer one item after a random gap and hold it until its transfer
   task automatic send_item(input req_type item);
      int gap;
      gap = 0;
      while (gap < GAP_CAP && $urandom_range(0, 99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (item.operation == OP_MODE)
         tb_mode = (tb_mode == MODE_FULL) ? MODE_OFF : tb_mode + 1'b1;
   endtask

   task automatic send_tick(input logic [TIME_W-1:0] now);
      clock_ms = now;
      send_item('{operation: OP_TICK, now_ms: now});
   endtask

   task automatic send_press();
      send_item('{operation: OP_MODE, now_ms: $urandom()});
   endtask

   task automatic press_to(input logic [MODE_W-1:0] target);
      while (tb_mode != target)
         send_press();
   endtask

   // stop offering and wait until every owed result has come
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_owed != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // write every register, plus one write to the unused index
   task automatic load_config(input logic [CSR_DATA_W-1:0] pwm,
                              input logic [CSR_DATA_W-1:0] breath,
                              input logic [CSR_DATA_W-1:0] off0,
                              input logic [CSR_DATA_W-1:0] off1,
                              input logic [CSR_DATA_W-1:0] off2,
                              input logic [CSR_DATA_W-1:0] invert,
                              input logic [CSR_DATA_W-1:0] interval);
      write_reg(CSR_PWM_PERIOD, pwm);
      write_reg(CSR_BREATH_PERIOD, breath);
      write_reg(CSR_OFFSET_CH0, off0);
      write_reg(CSR_OFFSET_CH1, off1);
      write_reg(CSR_OFFSET_CH2, off2);
      write_reg(CSR_INVERT_MASK, invert);
      write_reg(CSR_INTERVAL, interval);
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom()));
      csr_wr_en <= 1'b0;
      tb_breath   = breath[BREATH_W-1:0];
      tb_interval = interval[INTERVAL_W-1:0];
   endtask

   task automatic load_random_config();
      logic [CSR_DATA_W-1:0] pwm;
      logic [CSR_DATA_W-1:0] breath;
      logic [CSR_DATA_W-1:0] interval;
      pwm      = CSR_DATA_W'($urandom_range(0, 3) == 0 ? $urandom_range(1, 16)
                                                       : $urandom_range(1, 65536));
      breath   = CSR_DATA_W'($urandom_range(0, 1) == 0 ? $urandom_range(2, 200)
                                                       : $urandom_range(2, 65535));
      interval = CSR_DATA_W'($urandom_range(0, 1) == 0 ? $urandom_range(1, 20)
                                                       : $urandom_range(1, 255));
      load_config(pwm, breath, CSR_DATA_W'($urandom_range(0, 65535)),
                  CSR_DATA_W'($urandom_range(0, 65535)),
                  CSR_DATA_W'($urandom_range(0, 65535)),
                  CSR_DATA_W'($urandom_range(0, 7)), interval);
   endtask

   // mostly ticks that walk forward around the interval, some presses and jumps
   function automatic req_type random_item();
      req_type item;
      int      pick;
      pick = $urandom_range(0, 99);
      item.now_ms = $urandom();
      if (pick < 10) begin
         item.operation = OP_MODE;
      end else begin
         item.operation = OP_TICK;
         if (pick < 16) begin
            clock_ms = item.now_ms;
         end else begin
            if (pick < 24)
               clock_ms = clock_ms + $urandom_range(0, 2 * tb_breath);
            else
               clock_ms = clock_ms + $urandom_range(0, 2 * tb_interval + 2);
            item.now_ms = clock_ms;
         end
      end
      return item;
   endfunction

   task automatic run_random(input int count, input int idle_pct, input int stall_pct);
      req_type item;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) begin
         item = random_item();
         send_item(item);
      end
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed walk with reset registers: gaps below, at and over the interval
      send_tick(32'd0);
      send_tick(32'd9);
      send_press();
      send_tick(32'd10);
      send_tick(32'd760);
      send_tick(32'd1510);
      send_press();
      send_tick(32'd2250);
      send_press();
      send_tick(32'd2999);
      send_press();
      send_tick(32'hFFFF_FFFF);
      send_tick(32'h8000_0000);
      send_tick(32'h7FFF_FFFF);
      send_press();
      drain_results();

      // zero breathing period with all channels lit and inverted
      press_to(MODE_FULL);
      drain_results();
      load_config(RST_PWM_PERIOD, 17'd0, 17'd0, 17'd1000, 17'd2000, 17'd7, 17'd10);
      send_tick(clock_ms + 32'd20);
      send_tick(clock_ms + 32'd20);
      drain_results();
      // breathing period of one, progress pinned at zero
      load_config(RST_PWM_PERIOD, 17'd1, 17'd0, 17'd1000, 17'd2000, 17'd7, 17'd10);
      send_tick(clock_ms + 32'd20);
      drain_results();
      // zero interval, a repeated timestamp still updates
      load_config(RST_PWM_PERIOD, 17'd3000, 17'd0, 17'd1000, 17'd2000, 17'd0, 17'd0);
      send_tick(clock_ms + 32'd5);
      send_tick(clock_ms);
      send_tick(clock_ms + 32'd1);
      drain_results();

      // upper extremes, no idling
      load_config(17'd65536, 17'd65535, 17'd65535, 17'd65535, 17'd65535, 17'd7, 17'd255);
      run_random(120, 0, 0);
      drain_results();

      // lower extremes, sender mostly idle
      load_config(17'd1, 17'd2, 17'd0, 17'd0, 17'd0, 17'd0, 17'd1);
      run_random(120, 81, 0);
      drain_results();

      // receiver mostly stalling
      load_random_config();
      run_random(150, 0, 81);
      drain_results();
      load_random_config();
      run_random(150, 0, 81);
      drain_results();

      // long result hold-off while items keep coming, then a full pause
      load_random_config();
      press_to(MODE_BLUE);
      receiver_stall_pct = 0;
      hold_request = HOLD_CYCLES;
      run_random(40, 0, 0);
      drain_results();

      // both sides idling now and then
      load_random_config();
      run_random(150, 24, 24);
      drain_results();
      load_random_config();
      run_random(150, 24, 24);
      drain_results();

      // no idling
      load_random_config();
      run_random(150, 0, 0);
      drain_results();

      repeat (SETTLE_TIME) @(posedge clock);
      if (error_count == 0)
         $display("led_breathing_pwm_controller_tb: done, clean");
      else
         $display("led_breathing_pwm_controller_tb: done, errors");
      $finish;
   end

endmodule
